FILE: sv/wvp_pkg.sv
// ----------------------------------------------------------------------------
// Wheel velocity PID package
// Shared widths, register indexes and fixed-point constants.
// ----------------------------------------------------------------------------
package wvp_pkg;

  localparam int HISTORY_DEPTH_DEF = 8;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TPM       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STILL     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_MIN = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_MAX = 3'd6;

  // Serial multiplier: A is held, B is shifted out one bit per cycle.
  localparam int MUL_A_W = 48;
  localparam int MUL_B_W = 32;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // Serial divider: one quotient bit per cycle.
  localparam int DIV_N_W = 64;
  localparam int DIV_D_W = 48;

  localparam logic [MUL_A_W-1:0] MS_Q16    = 48'd65536000;
  localparam logic [MUL_B_W-1:0] MS_PER_S  = 32'd1000;
  localparam logic [DIV_D_W-1:0] MS_PER_SD = 48'd1000;

  localparam logic signed [15:0] LOW_BAND  = -16'sd13107;
  localparam logic signed [15:0] HIGH_BAND = 16'sd13107;

  localparam logic signed [47:0] LIM48    = 48'sh7FFF_FFFF_FFFF;
  localparam logic [40:0]        PROD_CAP = 41'h100_0000_0000;

endpackage

FILE: sv/wvp_if.sv
// ----------------------------------------------------------------------------
// Wheel velocity PID channels
// Valid/ready channels for encoder and tick items and for result items.
// ----------------------------------------------------------------------------
interface wvp_in_if;
  logic               valid;
  logic               ready;
  logic               command;
  logic signed [15:0] encoder_count;
  logic        [31:0] time_ms;
  logic signed [31:0] target_velocity;

  modport source (output valid, command, encoder_count, time_ms, target_velocity,
                  input ready);
  modport sink   (input valid, command, encoder_count, time_ms, target_velocity,
                  output ready);
endinterface

interface wvp_out_if;
  logic               valid;
  logic               ready;
  logic signed [8:0]  drive;
  logic signed [31:0] measured_velocity;
  logic               zero_interval;

  modport source (output valid, drive, measured_velocity, zero_interval, input ready);
  modport sink   (input valid, drive, measured_velocity, zero_interval, output ready);
endinterface

FILE: sv/wheel_velocity_pid.sv
// ----------------------------------------------------------------------------
// Wheel velocity PID
// Encoder unwrapping, velocity estimate, rolling mean and PID drive output.
// ----------------------------------------------------------------------------
// An encoder item is taken in the idle state and gives no result.
// A tick item gives its result through the shared serial multiplier and divider; a tick
// runs up to four multiplies, three gain products and four divides. One item is worked
// at a time, and a result that waits for the sink holds back the next tick's result.
// Synchronous active-low reset clears the state and loads register defaults.
// ----------------------------------------------------------------------------
module wheel_velocity_pid #(
  parameter int HISTORY_DEPTH = wvp_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  wvp_in_if.sink                         in_ch,
  wvp_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [wvp_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [wvp_pkg::CFG_DATA_W-1:0] cfg_data
);
  import wvp_pkg::*;

  localparam int SUM_W = 33 + $clog2(HISTORY_DEPTH);
  localparam int MOT_W = 44;

  typedef enum logic [14:0] {
    S_IDLE   = 15'b000000000000001,
    S_MDEN   = 15'b000000000000010,
    S_MNUM   = 15'b000000000000100,
    S_DVEL   = 15'b000000000001000,
    S_KEEP   = 15'b000000000010000,
    S_DAVG   = 15'b000000000100000,
    S_ERR    = 15'b000000001000000,
    S_MSTEP  = 15'b000000010000000,
    S_DSTEP  = 15'b000000100000000,
    S_MDER   = 15'b000001000000000,
    S_DDER   = 15'b000010000000000,
    S_GSTART = 15'b000100000000000,
    S_MGAIN  = 15'b001000000000000,
    S_CLAMP  = 15'b010000000000000,
    S_OUT    = 15'b100000000000000
  } state_t;

  function automatic logic signed [31:0] sat_mag(input logic [DIV_N_W-1:0] q,
                                                 input logic neg);
    if (neg) begin
      return (q >= 64'h8000_0000) ? 32'sh8000_0000 : $signed(~q[31:0] + 32'd1);
    end
    return (q > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(q[31:0]);
  endfunction

  function automatic logic signed [47:0] clamp48(input logic signed [49:0] v);
    if (v > LIM48) return LIM48;
    if (v < -LIM48) return -LIM48;
    return $signed(v[47:0]);
  endfunction

  function automatic logic [47:0] lim_mag(input logic [DIV_N_W-1:0] q);
    return (q > DIV_N_W'(LIM48)) ? LIM48 : q[47:0];
  endfunction

  // Configuration
  logic signed [31:0] gain_p_r, gain_p_nxt, gain_i_r, gain_i_nxt, gain_d_r, gain_d_nxt;
  logic        [15:0] tpm_r, tpm_nxt;
  logic        [30:0] still_r, still_nxt;
  logic signed [8:0]  drive_min_r, drive_min_nxt;
  logic        [7:0]  drive_max_r, drive_max_nxt;

  // State
  logic signed [15:0] last_raw_r, last_raw_nxt;
  logic        [15:0] wrap_r, wrap_nxt;
  logic        [31:0] pos_latest_r, pos_latest_nxt, pos_prev_r, pos_prev_nxt;
  logic        [31:0] vel_time_r, vel_time_nxt, ctl_time_r, ctl_time_nxt;
  logic signed [31:0] hist_r [HISTORY_DEPTH];
  logic signed [31:0] hist_nxt [HISTORY_DEPTH];
  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic signed [31:0] avg_r, avg_nxt;
  logic signed [47:0] integ_r, integ_nxt;
  logic signed [31:0] prev_err_r, prev_err_nxt;

  // Control
  state_t             state_r, state_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic        [1:0]  gsel_r, gsel_nxt;

  // Work registers
  logic        [31:0] t_r, t_nxt, pdt_r, pdt_nxt;
  logic signed [31:0] tgt_r, tgt_nxt;
  logic               moving_r, moving_nxt, mneg_r, mneg_nxt;
  logic        [31:0] mag_r, mag_nxt;
  logic        [47:0] den_r, den_nxt;
  logic signed [31:0] cur_r, cur_nxt;
  logic               flag_r, flag_nxt, aneg_r, aneg_nxt, gneg_r, gneg_nxt;
  logic signed [31:0] err_r, err_nxt;
  logic signed [47:0] old_int_r, old_int_nxt;
  logic signed [32:0] diff_r, diff_nxt;
  logic signed [47:0] deriv_r, deriv_nxt;
  logic signed [MOT_W-1:0] motor_r, motor_nxt;
  logic signed [8:0]  drive_r, drive_nxt;
  logic signed [31:0] meas_r, meas_nxt;
  logic               zflag_r, zflag_nxt;

  // Shared units
  logic               mul_start, mul_done, div_start, div_done;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_P_W-1:0] mul_p;
  logic [DIV_N_W-1:0] div_n, div_q;
  logic [DIV_D_W-1:0] div_d;

  // Combinational helpers
  logic               enc_up, enc_dn;
  logic        [31:0] moved, dt_c, pdt_c;
  logic               keep_push;
  logic signed [31:0] keep_val;
  logic signed [SUM_W-1:0] sum_push;
  logic        [SUM_W-1:0] sum_abs;
  logic signed [32:0] err_wide;
  logic signed [31:0] err_c;
  logic        [31:0] err_mag;
  logic        [47:0] step_m;
  logic signed [48:0] step_s;
  logic signed [49:0] int_sum;
  logic signed [32:0] diff_c;
  logic        [32:0] diff_mag;
  logic        [47:0] der_m;
  logic signed [31:0] g_sel;
  logic signed [47:0] x_sel;
  logic        [40:0] term_cap;
  logic        [MUL_P_W-17:0] term_raw;
  logic        [MOT_W-1:0] term_u;
  logic signed [MOT_W-1:0] term_s, mot_hi, mot_lo, mot_cl, mot_sg, mot_abs;
  logic signed [MOT_W-1:0] drv_mag;

  wvp_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_p)
  );

  wvp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_n),
    .den   (div_d),
    .done  (div_done),
    .quo   (div_q)
  );

  assign enc_up = (in_ch.encoder_count < LOW_BAND) && (last_raw_r > HIGH_BAND);
  assign enc_dn = (in_ch.encoder_count > HIGH_BAND) && (last_raw_r < LOW_BAND);

  assign moved = pos_latest_r - pos_prev_r;
  assign dt_c  = in_ch.time_ms - vel_time_r;
  assign pdt_c = in_ch.time_ms - ctl_time_r;

  // With no movement, a stale estimate under the threshold counts as stopped,
  // and one between zero and the current mean is kept as it is.
  always_comb begin
    keep_push = 1'b0;
    keep_val  = cur_r;
    if (moving_r) begin
      keep_push = 1'b1;
    end else if (cur_r < $signed({1'b0, still_r})) begin
      keep_push = 1'b1;
      keep_val  = '0;
    end else if ((avg_r >= 0 && avg_r > cur_r && cur_r >= 0) ||
                 (avg_r < 0 && avg_r < cur_r && cur_r <= 0)) begin
      keep_push = 1'b1;
    end
  end

  assign sum_push = sum_r + SUM_W'(keep_val) - SUM_W'(hist_r[HISTORY_DEPTH-1]);
  assign sum_abs  = sum_push[SUM_W-1] ? -sum_push : sum_push;

  assign err_wide = $signed({tgt_r[31], tgt_r}) - $signed({avg_r[31], avg_r});
  always_comb begin
    if (err_wide > 33'sh0_7FFF_FFFF) begin
      err_c = 32'sh7FFF_FFFF;
    end else if (err_wide < -33'sh0_8000_0000) begin
      err_c = 32'sh8000_0000;
    end else begin
      err_c = $signed(err_wide[31:0]);
    end
  end
  assign err_mag = err_c[31] ? (~err_c + 32'd1) : err_c;

  assign step_m  = lim_mag(div_q);
  assign step_s  = err_r[31] ? -$signed({1'b0, step_m}) : $signed({1'b0, step_m});
  assign int_sum = 50'(integ_r) + 50'(step_s);

  assign diff_c   = $signed({err_r[31], err_r}) - $signed({prev_err_r[31], prev_err_r});
  assign diff_mag = diff_c[32] ? (~diff_c + 33'd1) : diff_c;
  assign der_m    = lim_mag(div_q);

  always_comb begin
    case (gsel_r)
      2'd0:    begin g_sel = gain_p_r; x_sel = 48'(err_r);  end
      2'd1:    begin g_sel = gain_i_r; x_sel = integ_r;     end
      default: begin g_sel = gain_d_r; x_sel = deriv_r;     end
    endcase
  end

  // Each gain product is the floor of |a*b| / 2^16, capped at 2^40.
  assign term_raw = mul_p[MUL_P_W-1:16];
  assign term_cap = (term_raw > (MUL_P_W-16)'(PROD_CAP)) ? PROD_CAP : term_raw[40:0];
  assign term_u   = MOT_W'(term_cap);
  assign term_s   = gneg_r ? -$signed(term_u) : $signed(term_u);

  assign mot_hi = $signed({20'd0, drive_max_r, 16'd0});
  assign mot_lo = $signed({{19{drive_min_r[8]}}, drive_min_r, 16'd0});

  always_comb begin
    if (motor_r > mot_hi) begin
      mot_cl = mot_hi;
    end else if (motor_r < mot_lo) begin
      mot_cl = mot_lo;
    end else begin
      mot_cl = motor_r;
    end
    if (tgt_r > 0) begin
      mot_sg = (mot_cl < 0) ? '0 : mot_cl;
    end else if (tgt_r < 0) begin
      mot_sg = (mot_cl > 0) ? '0 : mot_cl;
    end else begin
      mot_sg = '0;
    end
  end

  // Drive is the Q28.16 value truncated toward zero.
  assign mot_abs = motor_r[MOT_W-1] ? -motor_r : motor_r;
  assign drv_mag = mot_abs >>> 16;

  always_comb begin
    gain_p_nxt    = gain_p_r;
    gain_i_nxt    = gain_i_r;
    gain_d_nxt    = gain_d_r;
    tpm_nxt       = tpm_r;
    still_nxt     = still_r;
    drive_min_nxt = drive_min_r;
    drive_max_nxt = drive_max_r;
    last_raw_nxt  = last_raw_r;
    wrap_nxt      = wrap_r;
    pos_latest_nxt = pos_latest_r;
    pos_prev_nxt  = pos_prev_r;
    vel_time_nxt  = vel_time_r;
    ctl_time_nxt  = ctl_time_r;
    hist_nxt      = hist_r;
    sum_nxt       = sum_r;
    avg_nxt       = avg_r;
    integ_nxt     = integ_r;
    prev_err_nxt  = prev_err_r;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    gsel_nxt      = gsel_r;
    t_nxt         = t_r;
    pdt_nxt       = pdt_r;
    tgt_nxt       = tgt_r;
    moving_nxt    = moving_r;
    mneg_nxt      = mneg_r;
    mag_nxt       = mag_r;
    den_nxt       = den_r;
    cur_nxt       = cur_r;
    flag_nxt      = flag_r;
    aneg_nxt      = aneg_r;
    gneg_nxt      = gneg_r;
    err_nxt       = err_r;
    old_int_nxt   = old_int_r;
    diff_nxt      = diff_r;
    deriv_nxt     = deriv_r;
    motor_nxt     = motor_r;
    drive_nxt     = drive_r;
    meas_nxt      = meas_r;
    zflag_nxt     = zflag_r;
    mul_start     = 1'b0;
    mul_a         = '0;
    mul_b         = '0;
    div_start     = 1'b0;
    div_n         = '0;
    div_d         = '0;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    if (cfg_we) begin
      unique case (cfg_idx)
        REG_GAIN_P:    gain_p_nxt    = $signed(cfg_data);
        REG_GAIN_I:    gain_i_nxt    = $signed(cfg_data);
        REG_GAIN_D:    gain_d_nxt    = $signed(cfg_data);
        REG_TPM:       tpm_nxt       = cfg_data[15:0];
        REG_STILL:     still_nxt     = cfg_data[30:0];
        REG_DRIVE_MIN: drive_min_nxt = $signed(cfg_data[8:0]);
        REG_DRIVE_MAX: drive_max_nxt = cfg_data[7:0];
        default: ;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          if (!in_ch.command) begin
            wrap_nxt       = wrap_r + {15'd0, enc_up} - {15'd0, enc_dn};
            pos_latest_nxt = {wrap_nxt, 16'd0} + 32'(in_ch.encoder_count);
            last_raw_nxt   = in_ch.encoder_count;
          end else begin
            t_nxt      = in_ch.time_ms;
            tgt_nxt    = in_ch.target_velocity;
            pdt_nxt    = pdt_c;
            moving_nxt = (moved != 32'd0);
            mneg_nxt   = moved[31];
            mag_nxt    = moved[31] ? (~moved + 32'd1) : moved;
            flag_nxt   = 1'b0;
            if (dt_c == 32'd0) begin
              flag_nxt  = 1'b1;
              cur_nxt   = (moved != 32'd0 && moved[31]) ? 32'sh8000_0000
                                                        : 32'sh7FFF_FFFF;
              state_nxt = S_KEEP;
            end else begin
              mul_start = 1'b1;
              mul_a     = MUL_A_W'((tpm_r == 16'd0) ? 16'd1 : tpm_r);
              mul_b     = dt_c;
              state_nxt = S_MDEN;
            end
          end
        end
      end
      S_MDEN: begin
        if (mul_done) begin
          den_nxt   = mul_p[47:0];
          mul_start = 1'b1;
          mul_a     = MS_Q16;
          mul_b     = moving_r ? mag_r : 32'd1;
          state_nxt = S_MNUM;
        end
      end
      S_MNUM: begin
        if (mul_done) begin
          div_start = 1'b1;
          div_n     = mul_p[DIV_N_W-1:0];
          div_d     = den_r;
          state_nxt = S_DVEL;
        end
      end
      S_DVEL: begin
        if (div_done) begin
          cur_nxt   = sat_mag(div_q, moving_r && mneg_r);
          state_nxt = S_KEEP;
        end
      end
      S_KEEP: begin
        if (moving_r) begin
          pos_prev_nxt = pos_latest_r;
          vel_time_nxt = t_r;
        end
        if (keep_push) begin
          for (int i = HISTORY_DEPTH - 1; i > 0; i--) begin
            hist_nxt[i] = hist_r[i-1];
          end
          hist_nxt[0] = keep_val;
          sum_nxt     = sum_push;
          aneg_nxt    = sum_push[SUM_W-1];
          div_start   = 1'b1;
          div_n       = DIV_N_W'(sum_abs);
          div_d       = DIV_D_W'(HISTORY_DEPTH);
          state_nxt   = S_DAVG;
        end else begin
          state_nxt = S_ERR;
        end
      end
      S_DAVG: begin
        if (div_done) begin
          avg_nxt   = aneg_r ? $signed(~div_q[31:0] + 32'd1) : $signed(div_q[31:0]);
          state_nxt = S_ERR;
        end
      end
      S_ERR: begin
        err_nxt      = err_c;
        ctl_time_nxt = t_r;
        mul_start    = 1'b1;
        mul_a        = MUL_A_W'(err_mag);
        mul_b        = pdt_r;
        state_nxt    = S_MSTEP;
      end
      S_MSTEP: begin
        if (mul_done) begin
          div_start = 1'b1;
          div_n     = mul_p[DIV_N_W-1:0];
          div_d     = MS_PER_SD;
          state_nxt = S_DSTEP;
        end
      end
      S_DSTEP: begin
        if (div_done) begin
          old_int_nxt  = integ_r;
          integ_nxt    = clamp48(int_sum);
          diff_nxt     = diff_c;
          prev_err_nxt = err_r;
          if (pdt_r == 32'd0) begin
            flag_nxt  = 1'b1;
            deriv_nxt = (diff_c > 0) ? LIM48 : ((diff_c < 0) ? -LIM48 : '0);
            gsel_nxt  = 2'd0;
            motor_nxt = '0;
            state_nxt = S_GSTART;
          end else begin
            mul_start = 1'b1;
            mul_a     = MUL_A_W'(diff_mag);
            mul_b     = MS_PER_S;
            state_nxt = S_MDER;
          end
        end
      end
      S_MDER: begin
        if (mul_done) begin
          div_start = 1'b1;
          div_n     = mul_p[DIV_N_W-1:0];
          div_d     = DIV_D_W'(pdt_r);
          state_nxt = S_DDER;
        end
      end
      S_DDER: begin
        if (div_done) begin
          deriv_nxt = diff_r[32] ? -$signed(der_m) : $signed(der_m);
          gsel_nxt  = 2'd0;
          motor_nxt = '0;
          state_nxt = S_GSTART;
        end
      end
      S_GSTART: begin
        mul_start = 1'b1;
        mul_a     = x_sel[47] ? (~x_sel + 48'd1) : x_sel;
        mul_b     = g_sel[31] ? (~g_sel + 32'd1) : g_sel;
        gneg_nxt  = g_sel[31] ^ x_sel[47];
        state_nxt = S_MGAIN;
      end
      S_MGAIN: begin
        if (mul_done) begin
          motor_nxt = motor_r + term_s;
          if (gsel_r == 2'd2) begin
            state_nxt = S_CLAMP;
          end else begin
            gsel_nxt  = gsel_r + 2'd1;
            state_nxt = S_GSTART;
          end
        end
      end
      S_CLAMP: begin
        // The integral step is undone whenever the upper or lower drive clamp acts.
        if (motor_r > mot_hi || motor_r < mot_lo) begin
          integ_nxt = old_int_r;
        end
        motor_nxt = mot_sg;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          drive_nxt     = motor_r[MOT_W-1] ? -$signed(drv_mag[8:0]) : $signed(drv_mag[8:0]);
          meas_nxt      = avg_r;
          zflag_nxt     = flag_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_p_r    <= '0;
      gain_i_r    <= '0;
      gain_d_r    <= '0;
      tpm_r       <= 16'd1;
      still_r     <= 31'd66;
      drive_min_r <= -9'sd255;
      drive_max_r <= 8'd255;
      last_raw_r  <= '0;
      wrap_r      <= '0;
      pos_latest_r <= '0;
      pos_prev_r  <= '0;
      vel_time_r  <= '0;
      ctl_time_r  <= '0;
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        hist_r[i] <= '0;
      end
      sum_r       <= '0;
      avg_r       <= '0;
      integ_r     <= '0;
      prev_err_r  <= '0;
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      gsel_r      <= '0;
    end else begin
      gain_p_r    <= gain_p_nxt;
      gain_i_r    <= gain_i_nxt;
      gain_d_r    <= gain_d_nxt;
      tpm_r       <= tpm_nxt;
      still_r     <= still_nxt;
      drive_min_r <= drive_min_nxt;
      drive_max_r <= drive_max_nxt;
      last_raw_r  <= last_raw_nxt;
      wrap_r      <= wrap_nxt;
      pos_latest_r <= pos_latest_nxt;
      pos_prev_r  <= pos_prev_nxt;
      vel_time_r  <= vel_time_nxt;
      ctl_time_r  <= ctl_time_nxt;
      hist_r      <= hist_nxt;
      sum_r       <= sum_nxt;
      avg_r       <= avg_nxt;
      integ_r     <= integ_nxt;
      prev_err_r  <= prev_err_nxt;
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      gsel_r      <= gsel_nxt;
    end
  end

  always_ff @(posedge clk) begin
    t_r       <= t_nxt;
    pdt_r     <= pdt_nxt;
    tgt_r     <= tgt_nxt;
    moving_r  <= moving_nxt;
    mneg_r    <= mneg_nxt;
    mag_r     <= mag_nxt;
    den_r     <= den_nxt;
    cur_r     <= cur_nxt;
    flag_r    <= flag_nxt;
    aneg_r    <= aneg_nxt;
    gneg_r    <= gneg_nxt;
    err_r     <= err_nxt;
    old_int_r <= old_int_nxt;
    diff_r    <= diff_nxt;
    deriv_r   <= deriv_nxt;
    motor_r   <= motor_nxt;
    drive_r   <= drive_nxt;
    meas_r    <= meas_nxt;
    zflag_r   <= zflag_nxt;
  end

  assign in_ch.ready              = (state_r == S_IDLE);
  assign out_ch.valid             = out_valid_r;
  assign out_ch.drive             = drive_r;
  assign out_ch.measured_velocity = meas_r;
  assign out_ch.zero_interval     = zflag_r;

  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("sequencer state is not one-hot");

  a_integral_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (integ_r <= LIM48) && (integ_r >= -LIM48))
    else $error("error integral outside its saturation range");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && !out_valid_r) |=> (out_valid_r && state_r == S_IDLE))
    else $error("finished tick did not load the result register");

  a_unit_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
    !(mul_start && div_start))
    else $error("multiplier and divider started together");

  a_drive_range: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> (drive_r <= 9'sd255) && (drive_r >= -9'sd255))
    else $error("drive result outside its range");

endmodule

FILE: sv/wvp_mul.sv
// ----------------------------------------------------------------------------
// Wheel velocity PID serial multiplier
// Unsigned shift-add multiplier, one bit of B per cycle.
// ----------------------------------------------------------------------------
module wvp_mul (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [wvp_pkg::MUL_A_W-1:0]  a,
  input  logic [wvp_pkg::MUL_B_W-1:0]  b,
  output logic                         done,
  output logic [wvp_pkg::MUL_P_W-1:0]  prod
);
  import wvp_pkg::*;

  localparam int CNT_W = $clog2(MUL_B_W);

  logic [MUL_A_W-1:0] a_r;
  logic [MUL_P_W-1:0] p_r;
  logic [MUL_P_W-1:0] p_nxt;
  logic [MUL_A_W:0]   acc;
  logic [CNT_W-1:0]   cnt_r;
  logic               busy_r;
  logic               done_r;

  // The upper half accumulates A while the lower half shifts B out.
  assign acc   = {1'b0, p_r[MUL_P_W-1:MUL_B_W]} + (p_r[0] ? {1'b0, a_r} : '0);
  assign p_nxt = {acc, p_r[MUL_B_W-1:1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(MUL_B_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a;
      p_r <= MUL_P_W'(b);
    end else if (busy_r) begin
      p_r <= p_nxt;
    end
  end

  assign done = done_r;
  assign prod = p_r;

endmodule

FILE: sv/wvp_div.sv
// ----------------------------------------------------------------------------
// Wheel velocity PID serial divider
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wvp_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [wvp_pkg::DIV_N_W-1:0]  num,
  input  logic [wvp_pkg::DIV_D_W-1:0]  den,
  output logic                         done,
  output logic [wvp_pkg::DIV_N_W-1:0]  quo
);
  import wvp_pkg::*;

  localparam int CNT_W = $clog2(DIV_N_W);

  logic [DIV_N_W-1:0] n_r;
  logic [DIV_D_W-1:0] d_r;
  logic [DIV_D_W-1:0] rem_r;
  logic [DIV_D_W:0]   trial;
  logic [DIV_D_W:0]   diff;
  logic               ge;
  logic [CNT_W-1:0]   cnt_r;
  logic               busy_r;
  logic               done_r;

  // The dividend shifts into the remainder; quotient bits shift in behind it.
  assign trial = {rem_r, n_r[DIV_N_W-1]};
  assign ge    = trial >= {1'b0, d_r};
  assign diff  = trial - {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIV_N_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      n_r   <= num;
      d_r   <= den;
      rem_r <= '0;
    end else if (busy_r) begin
      n_r   <= {n_r[DIV_N_W-2:0], ge};
      rem_r <= ge ? diff[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
    end
  end

  assign done = done_r;
  assign quo  = n_r;

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wheel velocity PID testbench
// Streams encoder and tick items through the block under random handshake
// pressure and compares every result item with an in-bench fixed-point model.
// ----------------------------------------------------------------------------
module tb;
  import wvp_pkg::*;

  typedef struct packed {
    logic               command;
    logic signed [15:0] encoder_count;
    logic        [31:0] time_ms;
    logic signed [31:0] target_velocity;
  } wheel_item_t;

  typedef struct packed {
    logic signed [8:0]  drive;
    logic signed [31:0] measured_velocity;
    logic               zero_interval;
  } drive_result_t;

  localparam longint LIMIT48  = 64'sh7FFF_FFFF_FFFF;
  localparam int     HIST_N   = HISTORY_DEPTH_DEF;
  localparam int     STALL_LIMIT = 20000;
  localparam int     SETTLE_CYCLES = 1000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  wvp_in_if  in_ch ();
  wvp_out_if out_ch ();

  wheel_velocity_pid dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  // Model copy of the registers.
  longint      m_gain_p, m_gain_i, m_gain_d;
  logic [15:0] m_tpm;
  logic [30:0] m_still;
  logic signed [8:0] m_drive_min;
  logic [7:0]  m_drive_max;

  // Model copy of the block state.
  logic signed [15:0] m_last_raw;
  logic [15:0] m_wraps;
  logic [31:0] m_pos_latest, m_pos_prev, m_vel_time, m_ctl_time;
  int          m_history [HIST_N];
  int          m_mean;
  longint      m_integral;
  int          m_prev_error;

  wheel_item_t   pending_items[$];
  drive_result_t expected_results[$];

  int send_idle_pct = 10;
  int recv_stall_pct = 83;
  int mismatches = 0;
  int ticks_sent = 0;
  int samples_sent = 0;
  int results_checked = 0;
  int quiet_cycles = 0;
  logic in_took = 1'b0;

  logic signed [15:0] gen_count;
  logic [31:0]        gen_time;

  function automatic int sat_magnitude(longint unsigned mag, bit neg);
    if (neg) return (mag >= 64'h8000_0000) ? 32'sh8000_0000 : int'(-longint'(mag));
    return (mag > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : int'(mag);
  endfunction

  function automatic longint clamp_48(longint v);
    if (v > LIMIT48) return LIMIT48;
    if (v < -LIMIT48) return -LIMIT48;
    return v;
  endfunction

  // Gain product in Q16.16, computed from two partial products and capped at 2^40.
  function automatic longint gain_product(longint a, longint b);
    bit neg;
    longint unsigned ua, ub, r;
    neg = (a < 0) != (b < 0);
    ua = (a < 0) ? -a : a;
    ub = (b < 0) ? -b : b;
    r = ((ua * (ub >> 24)) << 8) + ((ua * (ub & 64'hFF_FFFF)) >> 16);
    if (r > (64'd1 << 40)) r = 64'd1 << 40;
    return neg ? -longint'(r) : longint'(r);
  endfunction

  function automatic void push_velocity(int v);
    longint sum;
    sum = 0;
    for (int i = HIST_N - 1; i > 0; i--) m_history[i] = m_history[i-1];
    m_history[0] = v;
    for (int i = 0; i < HIST_N; i++) sum += m_history[i];
    m_mean = int'(sum / HIST_N);
  endfunction

  function automatic void predict_encoder(logic signed [15:0] e);
    if (e < LOW_BAND && m_last_raw > HIGH_BAND) m_wraps++;
    if (e > HIGH_BAND && m_last_raw < LOW_BAND) m_wraps--;
    m_pos_latest = {m_wraps, 16'h0} + {{16{e[15]}}, e};
    m_last_raw = e;
  endfunction

  function automatic drive_result_t predict_tick(logic [31:0] t, logic signed [31:0] tgt);
    drive_result_t r;
    logic [31:0] dt, pdt;
    longint unsigned tpm64, mag;
    longint err, step, old_int, diff, deriv, motor, hi, lo;
    int moved, cur;
    bit neg, flag;
    flag = 0;
    tpm64 = (m_tpm == 0) ? 64'd1 : longint'(m_tpm);
    dt = t - m_vel_time;
    if (m_pos_latest != m_pos_prev) begin
      moved = m_pos_latest - m_pos_prev;
      neg = moved < 0;
      mag = neg ? -longint'(moved) : longint'(moved);
      if (dt == 0) begin
        flag = 1;
        cur = neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else begin
        cur = sat_magnitude(mag * 64'd65536000 / (tpm64 * longint'(dt)), neg);
      end
      push_velocity(cur);
      m_pos_prev = m_pos_latest;
      m_vel_time = t;
    end else begin
      if (dt == 0) begin
        flag = 1;
        cur = 32'sh7FFF_FFFF;
      end else begin
        cur = sat_magnitude(64'd65536000 / (tpm64 * longint'(dt)), 0);
      end
      // Stale: a zero under the threshold, else kept only between zero and the mean.
      if (longint'(cur) < longint'(m_still)) begin
        push_velocity(0);
      end else if ((m_mean >= 0 && m_mean > cur && cur >= 0) ||
                   (m_mean < 0 && m_mean < cur && cur <= 0)) begin
        push_velocity(cur);
      end
    end

    pdt = t - m_ctl_time;
    m_ctl_time = t;
    err = longint'(tgt) - longint'(m_mean);
    if (err > 64'sh7FFF_FFFF) err = 64'sh7FFF_FFFF;
    if (err < -64'sh8000_0000) err = -64'sh8000_0000;

    mag = (err < 0) ? -err : err;
    mag = mag * longint'(pdt) / 64'd1000;
    step = (err < 0) ? -longint'(mag) : longint'(mag);
    old_int = m_integral;
    m_integral = clamp_48(clamp_48(m_integral + clamp_48(step)));

    diff = err - longint'(m_prev_error);
    if (pdt == 0) begin
      flag = 1;
      deriv = (diff > 0) ? LIMIT48 : ((diff < 0) ? -LIMIT48 : 0);
    end else begin
      deriv = clamp_48(diff * 1000 / longint'(pdt));
    end
    m_prev_error = int'(err);

    motor = gain_product(m_gain_p, err) + gain_product(m_gain_i, m_integral) +
            gain_product(m_gain_d, deriv);
    hi = longint'(m_drive_max) * 65536;
    lo = longint'(m_drive_min) * 65536;
    if (motor > hi) begin
      motor = hi;
      m_integral = old_int;
    end else if (motor < lo) begin
      motor = lo;
      m_integral = old_int;
    end
    if (tgt > 0) begin
      if (motor < 0) motor = 0;
    end else if (tgt < 0) begin
      if (motor > 0) motor = 0;
    end else begin
      motor = 0;
    end

    r.drive = 9'(motor / 65536);
    r.measured_velocity = m_mean;
    r.zero_interval = flag;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    mismatches++;
    $display("MISMATCH %s at %0t: got %0d, expected %0d", what, $realtime, got, want);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    case (idx)
      REG_GAIN_P:    m_gain_p = longint'(signed'(data));
      REG_GAIN_I:    m_gain_i = longint'(signed'(data));
      REG_GAIN_D:    m_gain_d = longint'(signed'(data));
      REG_TPM:       m_tpm = data[15:0];
      REG_STILL:     m_still = data[30:0];
      REG_DRIVE_MIN: m_drive_min = data[8:0];
      REG_DRIVE_MAX: m_drive_max = data[7:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic configure(int gp, int gi, int gd, int tpm, int still, int dmin, int dmax);
    write_reg(REG_GAIN_P, gp);
    write_reg(REG_GAIN_I, gi);
    write_reg(REG_GAIN_D, gd);
    write_reg(REG_TPM, tpm);
    write_reg(REG_STILL, still);
    write_reg(REG_DRIVE_MIN, dmin);
    write_reg(REG_DRIVE_MAX, dmax);
  endtask

  task automatic drain();
    while (pending_items.size() != 0 || in_ch.valid || expected_results.size() != 0)
      @(posedge clk);
    // Encoder items give no result, so let any last one settle.
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic int gain_value(bit extreme);
    if (extreme) return $urandom();
    return int'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
  endfunction

  task automatic queue_item(bit cmd, logic signed [15:0] cnt, logic [31:0] t,
                            logic signed [31:0] tgt);
    wheel_item_t it;
    it.command = cmd;
    it.encoder_count = cnt;
    it.time_ms = t;
    it.target_velocity = tgt;
    pending_items.push_back(it);
  endtask

  // Mostly smooth motion and steady time with random content, plus some noise.
  task automatic queue_random(int n);
    int pick;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(99);
      if ($urandom_range(99) < 50) begin
        if (pick < 75) gen_count = gen_count + 16'(int'($urandom_range(0, 600)) - 300);
        else if (pick < 90) gen_count = gen_count + 16'(int'($urandom_range(0, 60000)) - 30000);
        else gen_count = 16'($urandom());
        queue_item(1'b0, gen_count, $urandom(), $urandom());
      end else begin
        if (pick < 85) gen_time = gen_time + $urandom_range(1, 250);
        else if (pick < 93) gen_time = gen_time;
        else gen_time = $urandom();
        pick = $urandom_range(99);
        queue_item(1'b1, 16'($urandom()), gen_time,
                   (pick < 80) ? int'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000 :
                   (pick < 90) ? 32'sd0 : int'($urandom()));
      end
    end
  endtask

  always @(posedge clk) begin
    in_took <= in_ch.valid && in_ch.ready;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      if (in_ch.command) begin
        expected_results.push_back(predict_tick(in_ch.time_ms, in_ch.target_velocity));
        ticks_sent++;
      end else begin
        predict_encoder(in_ch.encoder_count);
        samples_sent++;
      end
    end
  end

  always @(negedge clk) begin
    if (rst_n && (!in_ch.valid || in_took)) begin
      if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        wheel_item_t it;
        it = pending_items.pop_front();
        in_ch.command <= it.command;
        in_ch.encoder_count <= it.encoder_count;
        in_ch.time_ms <= it.time_ms;
        in_ch.target_velocity <= it.target_velocity;
        in_ch.valid <= 1'b1;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
    out_ch.ready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result, drive", out_ch.drive, 0);
      end else begin
        drive_result_t want;
        want = expected_results.pop_front();
        if (out_ch.drive !== want.drive)
          report_mismatch("drive", out_ch.drive, want.drive);
        if (out_ch.measured_velocity !== want.measured_velocity)
          report_mismatch("measured_velocity", out_ch.measured_velocity,
                          want.measured_velocity);
        if (out_ch.zero_interval !== want.zero_interval)
          report_mismatch("zero_interval", out_ch.zero_interval, want.zero_interval);
        results_checked++;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Timeout: no item moved for %0d cycles", STALL_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.command = 1'b0;
    in_ch.encoder_count = '0;
    in_ch.time_ms = '0;
    in_ch.target_velocity = '0;
    out_ch.ready = 1'b0;
    m_gain_p = 0; m_gain_i = 0; m_gain_d = 0;
    m_tpm = 16'd1; m_still = 31'd66; m_drive_min = -9'sd255; m_drive_max = 8'd255;
    m_last_raw = '0; m_wraps = '0;
    m_pos_latest = '0; m_pos_prev = '0; m_vel_time = '0; m_ctl_time = '0;
    for (int i = 0; i < HIST_N; i++) m_history[i] = 0;
    m_mean = 0; m_integral = 0; m_prev_error = 0;
    gen_count = '0;
    gen_time = '0;

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // Directed items under the reset register values first.
    queue_item(1'b1, 16'sd0, 32'd0, 32'sd65536);
    queue_item(1'b0, 16'sd32767, '0, '0);
    queue_item(1'b1, '0, 32'd20, 32'sh7FFF_FFFF);
    queue_item(1'b0, -16'sd32768, '0, '0);
    queue_item(1'b1, '0, 32'd20, 32'sh8000_0000);
    queue_item(1'b1, '0, 32'd20, 32'sd0);
    queue_item(1'b1, '0, 32'd500, 32'sd65536);
    drain();

    configure(32'h0004_0000, 32'h0001_0000, 32'h0000_1000, 100, 66, -255, 255);
    queue_item(1'b0, 16'sd20000, '0, '0);
    queue_item(1'b0, -16'sd20000, '0, '0);       // wrap forward
    queue_item(1'b1, '0, 32'd100, 32'sd131072);
    queue_item(1'b0, 16'sd20000, '0, '0);        // wrap backward
    queue_item(1'b1, '0, 32'd100, -32'sd131072);
    queue_item(1'b0, 16'sd20100, '0, '0);
    queue_item(1'b1, '0, 32'd100, 32'sd65536);   // zero interval while moving
    queue_item(1'b1, '0, 32'd150, 32'sd65536);   // stale estimate
    queue_item(1'b1, '0, 32'd5000, 32'sd65536);
    queue_item(1'b1, '0, 32'hFFFF_FFFF, 32'sd65536);
    queue_item(1'b1, '0, 32'd10, 32'sd0);        // target zero, time wraps
    queue_item(1'b0, 16'sd20000, '0, '0);
    queue_item(1'b1, '0, 32'd10, -32'sd65536);
    drain();

    configure(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0, 0);
    queue_item(1'b0, 16'sd5, '0, '0);
    queue_item(1'b1, '0, 32'd30, 32'sd65536);
    queue_item(1'b1, '0, 32'd30, -32'sd65536);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      send_idle_pct  = (ph < 2) ? 10 : (ph < 4) ? 83 : 0;
      recv_stall_pct = (ph < 2) ? 83 : (ph < 4) ? 10 : 0;
      if (ph == 3)
        configure(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 65535, 32'h7FFF_FFFF,
                  -255, 255);
      else
        configure(gain_value(ph == 5), gain_value(0), gain_value(0),
                  (ph == 1) ? 65535 : $urandom_range(1, 2000),
                  (ph == 4) ? 0 : $urandom_range(0, 5000),
                  -int'($urandom_range(0, 255)), $urandom_range(0, 255));
      queue_random(200);
      drain();
    end

    $display("Sent %0d encoder items and %0d tick items over 9 register settings.",
             samples_sent, ticks_sent);
    $display("Checked %0d result items, %0d mismatches.", results_checked, mismatches);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/wvp_pkg.sv
sv/wvp_if.sv
sv/wvp_mul.sv
sv/wvp_div.sv
sv/wheel_velocity_pid.sv
tb/tb.sv
